// ----- rtl/bpuv_pkg.sv -----
// Shared constants and types for the box paint union volume block.
package bpuv_pkg;

	localparam int LIMIT_W      = 21;
	localparam int CFG_DATA_W   = 21;
	localparam int CFG_IDX_W    = 1;
	localparam int VOL_W        = 63;
	localparam int QUEUE_DEPTH  = 4;

	localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_LIMIT  = 1'b1;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 21'd50;
	localparam logic [VOL_W-1:0]   VOL_MAX     = {VOL_W{1'b1}};

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_INS_HI,
		ST_SHIFT,
		ST_CELL,
		ST_SCAN,
		ST_DRAIN,
		ST_MUL1,
		ST_MUL2,
		ST_ACC,
		ST_OUT
	} back_state_t;

endpackage

// ----- rtl/bpuv_if.sv -----
// Box input and result channel interfaces.
interface bpuv_box_if #(
	parameter int COORD_BITS = 22
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] x_low;
	logic signed [COORD_BITS-1:0] x_high;
	logic signed [COORD_BITS-1:0] y_low;
	logic signed [COORD_BITS-1:0] y_high;
	logic signed [COORD_BITS-1:0] z_low;
	logic signed [COORD_BITS-1:0] z_high;
	logic                         turn_on;
	logic                         last_box;

	modport source (output valid, x_low, x_high, y_low, y_high, z_low, z_high,
		turn_on, last_box, input ready);
	modport sink (input valid, x_low, x_high, y_low, y_high, z_low, z_high,
		turn_on, last_box, output ready);
endinterface

interface bpuv_res_if;
	logic                          valid;
	logic                          ready;
	logic [bpuv_pkg::VOL_W-1:0]    volume;
	logic                          overflow;

	modport source (output valid, volume, overflow, input ready);
	modport sink (input valid, volume, overflow, output ready);
endinterface

// ----- rtl/box_paint_union_volume_core.sv -----
// Box words enter a four-word queue at one per cycle while it is not full; the back part stores
// each kept box, up to MAX_BOXES, and sorts its edges. After the word marked last, a sweep
// moves the sorted edges into pair RAMs, then every compressed cell (d0*d1*d2 of them, one
// fewer than the distinct edges per axis) takes a scan of the box RAM for the last box
// covering it, two multiply stages and the saturating add. The one result word
// sits in an output register so the next set can start loading while it waits.
module box_paint_union_volume_core #(
	parameter int MAX_BOXES  = 16,
	parameter int COORD_BITS = 22
) (
	input  logic                            clk,
	input  logic                            arst_n,
	bpuv_box_if.sink                        box,
	bpuv_res_if.source                      result,
	input  logic                            cfg_we,
	input  logic [bpuv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bpuv_pkg::CFG_DATA_W-1:0] cfg_data
);
	localparam int EW = 6 * COORD_BITS + 3;

	logic          push;
	logic [EW-1:0] push_data;
	logic          full;
	logic          pop;
	logic [EW-1:0] head;
	logic          empty;

	bpuv_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.box       (box),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	bpuv_queue #(.WIDTH(EW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	bpuv_back #(.MAX_BOXES(MAX_BOXES), .COORD_BITS(COORD_BITS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (empty),
		.q_head  (head),
		.pop     (pop),
		.result  (result)
	);
endmodule

// ----- rtl/bpuv_ram.sv -----
// Generic simple dual-port RAM with registered read.
module bpuv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/bpuv_queue.sv -----
// Short word queue between the front and back parts.
module bpuv_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output logic             empty
);
	localparam int DEPTH = bpuv_pkg::QUEUE_DEPTH;
	localparam int PW    = $clog2(DEPTH);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [PW:0]      fill_q;

	assign full  = fill_q == (PW+1)'(DEPTH);
	assign empty = fill_q == '0;
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end
endmodule

// ----- rtl/bpuv_front.sv -----
// Front part: config registers, limit filter and queue push.
module bpuv_front #(
	parameter int COORD_BITS = 22
) (
	input  logic                              clk,
	input  logic                              arst_n,
	bpuv_box_if.sink                          box,
	input  logic                              cfg_we,
	input  logic [bpuv_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bpuv_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                              push,
	output logic [6*COORD_BITS+2:0]           push_data,
	input  logic                              full
);
	localparam int CB = COORD_BITS;
	localparam int CW = (CB > bpuv_pkg::LIMIT_W ? CB : bpuv_pkg::LIMIT_W) + 2;

	logic                             filter_enable_q;
	logic [bpuv_pkg::LIMIT_W-1:0]     filter_limit_q;
	logic signed [CW-1:0]             lim;
	logic signed [CW-1:0]             neg_lim;
	logic                             keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_enable_q <= 1'b0;
			filter_limit_q  <= bpuv_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == bpuv_pkg::REG_FILTER_ENABLE) begin
				filter_enable_q <= cfg_data[0];
			end else if (cfg_index == bpuv_pkg::REG_FILTER_LIMIT) begin
				filter_limit_q <= cfg_data[bpuv_pkg::LIMIT_W-1:0];
			end
		end
	end

	always_comb begin
		lim     = $signed({{(CW-bpuv_pkg::LIMIT_W){1'b0}}, filter_limit_q});
		neg_lim = -lim;
		keep    = 1'b1;
		if (filter_enable_q) begin
			if (CW'(box.x_low) < neg_lim || CW'(box.x_high) > lim ||
				CW'(box.y_low) < neg_lim || CW'(box.y_high) > lim ||
				CW'(box.z_low) < neg_lim || CW'(box.z_high) > lim) begin
				keep = 1'b0;
			end
		end
	end

	assign box.ready = !full;
	assign push      = box.valid && !full;
	assign push_data = {box.last_box, keep, box.turn_on, box.z_high, box.z_low,
		box.y_high, box.y_low, box.x_high, box.x_low};
endmodule

// ----- rtl/bpuv_back.sv -----
// Back part: box store, edge sort, per-cell cover scan and volume sum.
module bpuv_back #(
	parameter int MAX_BOXES  = 16,
	parameter int COORD_BITS = 22
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_empty,
	input  logic [6*COORD_BITS+2:0] q_head,
	output logic                    pop,
	bpuv_res_if.source              result
);
	localparam int CB   = COORD_BITS;
	localparam int ME   = 2 * MAX_BOXES;
	localparam int NW   = $clog2(ME + 1);
	localparam int EAW  = $clog2(ME);
	localparam int BAW  = MAX_BOXES > 1 ? $clog2(MAX_BOXES) : 1;
	localparam int CNTW = $clog2(MAX_BOXES + 1);
	localparam int PW   = 3 * CB;
	localparam int VW   = bpuv_pkg::VOL_W;

	bpuv_pkg::back_state_t st_q, st_d;

	logic [CNTW-1:0]           cnt_q;
	logic                      ovf_q;
	logic                      last_q;
	logic signed [CB-1:0]      hi_q [3];
	logic signed [CB-1:0]      list_q [3][ME];
	logic signed [CB-1:0]      ins_list [3][ME];
	logic                      ins_ok [3];
	logic [ME-1:0]             lt [3];
	logic [ME-1:0]             eq [3];
	logic signed [CB-1:0]      ins_val [3];
	logic [NW-1:0]             n_q [3];
	logic [NW-1:0]             k_q;
	logic signed [CB-1:0]      prev_q [3];
	logic [EAW-1:0]            ix_q, iy_q, iz_q;
	logic [BAW-1:0]            b_q;
	logic                      bv_q;
	logic                      on_q;
	logic [2*CB-1:0]           dxy_q;
	logic [CB-1:0]             dz_q;
	logic [2*CB-1:0]           p0_q, p1_q;
	logic [VW-1:0]             sum_q;
	logic                      res_valid_q;
	logic [VW-1:0]             res_vol_q;
	logic                      res_ovf_q;

	logic                      h_last, h_keep;
	logic                      store_ok;
	logic                      short_set;
	logic                      scan_last;
	logic                      cells_done;
	logic                      out_free;
	logic                      covered;
	logic [2*CB-1:0]           edge_rd [3];
	logic [6*CB:0]             box_rd;
	logic signed [CB:0]        diff [3];
	logic [PW-1:0]             v;
	logic [PW+VW-1:0]          v_ext;
	logic [VW-1:0]             v_sat;
	logic [VW:0]               sum_add;
	logic [EAW-1:0]            e_addr [3];

	assign h_last   = q_head[6*CB+2];
	assign h_keep   = q_head[6*CB+1];
	assign store_ok = h_keep && (cnt_q < CNTW'(MAX_BOXES));
	assign pop      = (st_q == bpuv_pkg::ST_LOAD) && !q_empty;
	assign out_free = !res_valid_q || result.ready;

	assign short_set = (n_q[0] < NW'(2)) || (n_q[1] < NW'(2)) || (n_q[2] < NW'(2));
	assign scan_last = b_q == BAW'(cnt_q - 1'b1);
	assign cells_done = (ix_q == EAW'(n_q[0] - 2'd2)) && (iy_q == EAW'(n_q[1] - 2'd2))
		&& (iz_q == EAW'(n_q[2] - 2'd2));

	// sorted insert into each axis row; duplicates are dropped
	always_comb begin
		for (int ax = 0; ax < 3; ax++) begin
			ins_val[ax] = (st_q == bpuv_pkg::ST_INS_HI) ? hi_q[ax]
				: $signed(q_head[2*ax*CB +: CB]);
			for (int i = 0; i < ME; i++) begin
				lt[ax][i] = (NW'(i) < n_q[ax]) && (list_q[ax][i] < ins_val[ax]);
				eq[ax][i] = (NW'(i) < n_q[ax]) && (list_q[ax][i] == ins_val[ax]);
			end
			ins_ok[ax] = (eq[ax] == '0) && (n_q[ax] < NW'(ME));
			for (int i = 0; i < ME; i++) begin
				if (lt[ax][i]) begin
					ins_list[ax][i] = list_q[ax][i];
				end else if (i == 0) begin
					ins_list[ax][i] = ins_val[ax];
				end else if (lt[ax][i-1]) begin
					ins_list[ax][i] = ins_val[ax];
				end else begin
					ins_list[ax][i] = list_q[ax][i-1];
				end
			end
		end
	end

	assign e_addr[0] = ix_q;
	assign e_addr[1] = iy_q;
	assign e_addr[2] = iz_q;

	for (genvar ax = 0; ax < 3; ax++) begin : g_edge
		logic we;
		assign we = (st_q == bpuv_pkg::ST_SHIFT) && (k_q != '0) && (k_q < n_q[ax]);
		bpuv_ram #(.WIDTH(2*CB), .DEPTH(ME)) u_edge_ram (
			.clk   (clk),
			.we    (we),
			.waddr (EAW'(k_q - 1'b1)),
			.wdata ({list_q[ax][0], prev_q[ax]}),
			.raddr (e_addr[ax]),
			.rdata (edge_rd[ax])
		);
	end

	bpuv_ram #(.WIDTH(6*CB+1), .DEPTH(MAX_BOXES)) u_box_ram (
		.clk   (clk),
		.we    (pop && store_ok),
		.waddr (BAW'(cnt_q)),
		.wdata (q_head[6*CB:0]),
		.raddr (b_q),
		.rdata (box_rd)
	);

	always_comb begin
		covered = 1'b1;
		for (int ax = 0; ax < 3; ax++) begin
			if (!($signed(edge_rd[ax][2*CB-1:CB]) > $signed(box_rd[2*ax*CB +: CB]) &&
				$signed(edge_rd[ax][CB-1:0]) < $signed(box_rd[(2*ax+1)*CB +: CB]))) begin
				covered = 1'b0;
			end
			diff[ax] = (CB+1)'($signed(edge_rd[ax][2*CB-1:CB]))
				- (CB+1)'($signed(edge_rd[ax][CB-1:0]));
		end
		v       = {p1_q, {CB{1'b0}}} + PW'(p0_q);
		v_ext   = (PW+VW)'(v);
		v_sat   = (v_ext > (PW+VW)'(bpuv_pkg::VOL_MAX)) ? bpuv_pkg::VOL_MAX : VW'(v);
		sum_add = {1'b0, sum_q} + {1'b0, v_sat};
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			bpuv_pkg::ST_LOAD: begin
				if (!q_empty) begin
					if (store_ok) begin
						st_d = bpuv_pkg::ST_INS_HI;
					end else if (h_last) begin
						st_d = bpuv_pkg::ST_SHIFT;
					end
				end
			end
			bpuv_pkg::ST_INS_HI: st_d = last_q ? bpuv_pkg::ST_SHIFT : bpuv_pkg::ST_LOAD;
			bpuv_pkg::ST_SHIFT: begin
				if (k_q == NW'(ME - 1)) begin
					st_d = short_set ? bpuv_pkg::ST_OUT : bpuv_pkg::ST_CELL;
				end
			end
			bpuv_pkg::ST_CELL:  st_d = bpuv_pkg::ST_SCAN;
			bpuv_pkg::ST_SCAN:  st_d = scan_last ? bpuv_pkg::ST_DRAIN : bpuv_pkg::ST_SCAN;
			bpuv_pkg::ST_DRAIN: st_d = bpuv_pkg::ST_MUL1;
			bpuv_pkg::ST_MUL1:  st_d = bpuv_pkg::ST_MUL2;
			bpuv_pkg::ST_MUL2:  st_d = bpuv_pkg::ST_ACC;
			bpuv_pkg::ST_ACC:   st_d = cells_done ? bpuv_pkg::ST_OUT : bpuv_pkg::ST_CELL;
			bpuv_pkg::ST_OUT:   st_d = out_free ? bpuv_pkg::ST_LOAD : bpuv_pkg::ST_OUT;
			default:            st_d = bpuv_pkg::ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= bpuv_pkg::ST_LOAD;
		end else begin
			st_q <= st_d;
		end
	end

	// payload: edge rows, products, cell pointers
	always_ff @(posedge clk) begin
		case (st_q)
			bpuv_pkg::ST_LOAD: begin
				last_q <= h_last;
				for (int ax = 0; ax < 3; ax++) begin
					hi_q[ax] <= $signed(q_head[(2*ax+1)*CB +: CB]);
					if (pop && store_ok && ins_ok[ax]) begin
						list_q[ax] <= ins_list[ax];
					end
				end
			end
			bpuv_pkg::ST_INS_HI: begin
				for (int ax = 0; ax < 3; ax++) begin
					if (ins_ok[ax]) begin
						list_q[ax] <= ins_list[ax];
					end
				end
			end
			bpuv_pkg::ST_SHIFT: begin
				for (int ax = 0; ax < 3; ax++) begin
					prev_q[ax] <= list_q[ax][0];
					for (int i = 0; i < ME - 1; i++) begin
						list_q[ax][i] <= list_q[ax][i+1];
					end
				end
				ix_q <= '0;
				iy_q <= '0;
				iz_q <= '0;
			end
			bpuv_pkg::ST_MUL1: begin
				dxy_q <= diff[0][CB-1:0] * diff[1][CB-1:0];
				dz_q  <= diff[2][CB-1:0];
			end
			bpuv_pkg::ST_MUL2: begin
				p0_q <= dxy_q[CB-1:0] * dz_q;
				p1_q <= dxy_q[2*CB-1:CB] * dz_q;
			end
			bpuv_pkg::ST_ACC: begin
				if (iz_q == EAW'(n_q[2] - 2'd2)) begin
					iz_q <= '0;
					if (iy_q == EAW'(n_q[1] - 2'd2)) begin
						iy_q <= '0;
						ix_q <= ix_q + 1'b1;
					end else begin
						iy_q <= iy_q + 1'b1;
					end
				end else begin
					iz_q <= iz_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			k_q         <= '0;
			b_q         <= '0;
			bv_q        <= 1'b0;
			on_q        <= 1'b0;
			sum_q       <= '0;
			res_valid_q <= 1'b0;
			res_vol_q   <= '0;
			res_ovf_q   <= 1'b0;
			for (int ax = 0; ax < 3; ax++) begin
				n_q[ax] <= '0;
			end
		end else begin
			// in ST_OUT the valid flag is reloaded below
			if (res_valid_q && result.ready && st_q != bpuv_pkg::ST_OUT) begin
				res_valid_q <= 1'b0;
			end
			bv_q <= (st_q == bpuv_pkg::ST_SCAN);
			if (bv_q && covered) begin
				on_q <= box_rd[6*CB];
			end
			case (st_q)
				bpuv_pkg::ST_LOAD: begin
					k_q <= '0;
					if (pop) begin
						if (store_ok) begin
							cnt_q <= cnt_q + 1'b1;
							for (int ax = 0; ax < 3; ax++) begin
								if (ins_ok[ax]) begin
									n_q[ax] <= n_q[ax] + 1'b1;
								end
							end
						end else if (h_keep) begin
							ovf_q <= 1'b1;
						end
					end
				end
				bpuv_pkg::ST_INS_HI: begin
					for (int ax = 0; ax < 3; ax++) begin
						if (ins_ok[ax]) begin
							n_q[ax] <= n_q[ax] + 1'b1;
						end
					end
				end
				bpuv_pkg::ST_SHIFT: begin
					k_q   <= k_q + 1'b1;
					sum_q <= '0;
				end
				bpuv_pkg::ST_CELL: begin
					b_q  <= '0;
					on_q <= 1'b0;
				end
				bpuv_pkg::ST_SCAN: begin
					b_q <= b_q + 1'b1;
				end
				bpuv_pkg::ST_ACC: begin
					if (on_q) begin
						sum_q <= sum_add[VW] ? bpuv_pkg::VOL_MAX : sum_add[VW-1:0];
					end
				end
				bpuv_pkg::ST_OUT: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						res_vol_q   <= sum_q;
						res_ovf_q   <= ovf_q;
						cnt_q       <= '0;
						ovf_q       <= 1'b0;
						for (int ax = 0; ax < 3; ax++) begin
							n_q[ax] <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign result.valid    = res_valid_q;
	assign result.volume   = res_vol_q;
	assign result.overflow = res_ovf_q;
endmodule

// ----- test/bpuv_volume_checker.sv -----
// Checker: predicts union volume per box set and compares result words.
`timescale 1ns / 100ps
module bpuv_volume_checker #(
	parameter int MAX_BOXES = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	bpuv_box_if                             box,
	bpuv_res_if                             result,
	input  logic                            cfg_we,
	input  logic [bpuv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bpuv_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              errors,
	output int                              pending
);
	localparam int MAX_EDGES = 2 * MAX_BOXES;
	localparam int VW = bpuv_pkg::VOL_W;
	localparam longint unsigned SAT = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef struct {
		logic [VW-1:0] volume;
		logic          overflow;
	} volume_word_t;

	volume_word_t   volume_q[$];
	longint         stored_bounds[MAX_BOXES][6];
	bit             stored_on[MAX_BOXES];
	int             stored_cnt;
	bit             dropped;
	bit             flt_en;
	longint         flt_lim;
	longint         edges[3][MAX_EDGES];
	int             n_edges[3];
	bit             grid[MAX_EDGES*MAX_EDGES*MAX_EDGES];

	assign pending = volume_q.size();

	function automatic void add_edge(int ax, longint e);
		int pos;
		pos = 0;
		while (pos < n_edges[ax] && edges[ax][pos] < e)
			pos++;
		if (pos < n_edges[ax] && edges[ax][pos] == e)
			return;
		if (n_edges[ax] >= MAX_EDGES)
			return;
		for (int i = n_edges[ax]; i > pos; i--)
			edges[ax][i] = edges[ax][i-1];
		edges[ax][pos] = e;
		n_edges[ax]++;
	endfunction

	function automatic longint unsigned union_volume();
		longint unsigned sum, dx, dy, dz, dxy, v;
		int d0, d1, d2;
		sum = 0;
		for (int a = 0; a < 3; a++)
			n_edges[a] = 0;
		for (int b = 0; b < stored_cnt; b++)
			for (int a = 0; a < 3; a++) begin
				add_edge(a, stored_bounds[b][2*a]);
				add_edge(a, stored_bounds[b][2*a+1]);
			end
		if (n_edges[0] < 2 || n_edges[1] < 2 || n_edges[2] < 2)
			return 0;
		d0 = n_edges[0] - 1;
		d1 = n_edges[1] - 1;
		d2 = n_edges[2] - 1;
		for (int i = 0; i < d0*d1*d2; i++)
			grid[i] = 0;
		// paint in arrival order, last writer wins
		for (int b = 0; b < stored_cnt; b++)
			for (int ix = 0; ix < d0; ix++) begin
				if (edges[0][ix+1] <= stored_bounds[b][0] || edges[0][ix] >= stored_bounds[b][1])
					continue;
				for (int iy = 0; iy < d1; iy++) begin
					if (edges[1][iy+1] <= stored_bounds[b][2] ||
							edges[1][iy] >= stored_bounds[b][3])
						continue;
					for (int iz = 0; iz < d2; iz++) begin
						if (edges[2][iz+1] <= stored_bounds[b][4] ||
								edges[2][iz] >= stored_bounds[b][5])
							continue;
						grid[(ix*d1 + iy)*d2 + iz] = stored_on[b];
					end
				end
			end
		for (int ix = 0; ix < d0; ix++)
			for (int iy = 0; iy < d1; iy++)
				for (int iz = 0; iz < d2; iz++) begin
					if (!grid[(ix*d1 + iy)*d2 + iz])
						continue;
					dx = edges[0][ix+1] - edges[0][ix];
					dy = edges[1][iy+1] - edges[1][iy];
					dz = edges[2][iz+1] - edges[2][iz];
					dxy = dx * dy;
					v = (dxy > SAT / dz) ? SAT : dxy * dz;
					sum = (v > SAT - sum) ? SAT : sum + v;
				end
		return sum;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		longint c[6];
		bit keep;
		volume_word_t w;
		volume_word_t got;
		if (!arst_n) begin
			stored_cnt = 0;
			dropped = 0;
			flt_en = 0;
			flt_lim = longint'(bpuv_pkg::LIMIT_RESET);
			errors = 0;
			volume_q.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == bpuv_pkg::REG_FILTER_ENABLE)
					flt_en = cfg_data[0];
				else if (cfg_index == bpuv_pkg::REG_FILTER_LIMIT)
					flt_lim = longint'(cfg_data);
			end
			if (box.valid && box.ready) begin
				c[0] = longint'(box.x_low);  c[1] = longint'(box.x_high);
				c[2] = longint'(box.y_low);  c[3] = longint'(box.y_high);
				c[4] = longint'(box.z_low);  c[5] = longint'(box.z_high);
				keep = 1;
				if (flt_en)
					for (int a = 0; a < 3; a++)
						if (c[2*a] < -flt_lim || c[2*a+1] > flt_lim)
							keep = 0;
				if (keep) begin
					if (stored_cnt >= MAX_BOXES)
						dropped = 1;
					else begin
						for (int i = 0; i < 6; i++)
							stored_bounds[stored_cnt][i] = c[i];
						stored_on[stored_cnt] = box.turn_on;
						stored_cnt++;
					end
				end
				if (box.last_box) begin
					w.volume = VW'(union_volume());
					w.overflow = dropped;
					volume_q = {volume_q, w};
					stored_cnt = 0;
					dropped = 0;
				end
			end
			if (result.valid && result.ready) begin
				if (volume_q.size() == 0) begin
					$error("result word with no expected volume");
					errors++;
				end else begin
					got = volume_q.pop_front();
					if (result.volume !== got.volume) begin
						$error("volume: expected %0d, got %0d", got.volume, result.volume);
						errors++;
					end
					if (result.overflow !== got.overflow) begin
						$error("overflow: expected %0d, got %0d", got.overflow,
							result.overflow);
						errors++;
					end
				end
			end
		end
	end
endmodule

// ----- test/tb.sv -----
// Testbench top: drives box sets and configuration, gives the verdict.
`timescale 1ns / 100ps
module tb;
	localparam int WATCHDOG = 200000;
	localparam int CB = 22;
	localparam int CMAX = 2097151;
	localparam int CMIN = -2097152;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [bpuv_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [bpuv_pkg::CFG_DATA_W-1:0] cfg_data;
	int                              errors;
	int                              pending;
	int                              idle_cycles;
	int                              n_items;
	int                              n_sets;
	int                              n_full_sets;
	bit                              calm;
	bit                              stall_req;
	bit                              held;
	int                              pool_off[3];
	int                              pool_step[3];

	bpuv_box_if #(.COORD_BITS(CB)) box_if ();
	bpuv_res_if res_if ();

	box_paint_union_volume_core #(.MAX_BOXES(16), .COORD_BITS(CB)) DUT (
		.clk(clk), .arst_n(arst_n), .box(box_if.sink), .result(res_if.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	bpuv_volume_checker #(.MAX_BOXES(16)) u_checker (
		.clk(clk), .arst_n(arst_n), .box(box_if), .result(res_if),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	initial clk = 0;
	always #10 clk = ~clk;

	// watchdog on stretches with no accepted word
	always @(posedge clk) begin
		if ((box_if.valid && box_if.ready) || (res_if.valid && res_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("watchdog expired, %0d volumes outstanding", pending);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// result side: short random stalls, one long hold-off on request
	initial begin
		res_if.ready = 0;
		held = 0;
		forever begin
			@(negedge clk);
			if (stall_req && !held) begin
				held = 1;
				res_if.ready = 0;
				repeat (300) @(negedge clk);
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				res_if.ready = 0;
				repeat ($urandom_range(0, 3)) @(negedge clk);
			end else
				res_if.ready = 1;
		end
	end

	task automatic write_reg(logic [bpuv_pkg::CFG_IDX_W-1:0] idx, int val);
		@(negedge clk);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = bpuv_pkg::CFG_DATA_W'(val);
		@(negedge clk);
		cfg_we = 0;
	endtask

	task automatic wait_drained();
		while (pending != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic send_box(int xl, int xh, int yl, int yh, int zl, int zh,
			bit on, bit last);
		if (!calm && $urandom_range(0, 3) == 0) begin
			box_if.valid = 0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		box_if.x_low = CB'(xl);  box_if.x_high = CB'(xh);
		box_if.y_low = CB'(yl);  box_if.y_high = CB'(yh);
		box_if.z_low = CB'(zl);  box_if.z_high = CB'(zh);
		box_if.turn_on = on;
		box_if.last_box = last;
		box_if.valid = 1;
		@(posedge clk);
		while (!box_if.ready)
			@(posedge clk);
		@(negedge clk);
		box_if.valid = 0;
		n_items++;
		if (last)
			n_sets++;
	endtask

	function automatic int pick_coord(int ax, bit wide);
		if (wide)
			return $signed(22'($urandom));
		return pool_off[ax] + pool_step[ax] * $urandom_range(0, 5);
	endfunction

	task automatic random_set();
		int nb, c[6];
		bit full, wide;
		full = ($urandom_range(0, 19) == 0);
		nb = full ? $urandom_range(17, 19) : $urandom_range(1, 5);
		for (int a = 0; a < 3; a++) begin
			pool_off[a] = $urandom_range(0, 120) - 60;
			pool_step[a] = $urandom_range(1, 30);
		end
		if (full)
			n_full_sets++;
		for (int b = 0; b < nb; b++) begin
			wide = !full && ($urandom_range(0, 4) == 0);
			for (int i = 0; i < 6; i++)
				c[i] = pick_coord(i / 2, wide);
			send_box(c[0], c[1], c[2], c[3], c[4], c[5], 1'($urandom_range(0, 1)),
				b == nb - 1);
		end
	endtask

	initial begin
		n_items = 0;
		n_sets = 0;
		n_full_sets = 0;
		calm = 0;
		stall_req = 0;
		cfg_we = 0;
		cfg_index = bpuv_pkg::REG_FILTER_ENABLE;
		cfg_data = 0;
		box_if.valid = 0;
		box_if.x_low = 0;  box_if.x_high = 0;
		box_if.y_low = 0;  box_if.y_high = 0;
		box_if.z_low = 0;  box_if.z_high = 0;
		box_if.turn_on = 0;
		box_if.last_box = 0;
		arst_n = 0;
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: single 2x2x2 box, empty box, on then off, full range saturation
		send_box(0, 2, 0, 2, 0, 2, 1, 1);
		send_box(5, 3, 0, 2, 0, 2, 1, 1);
		send_box(0, 4, 0, 4, 0, 4, 1, 0);
		send_box(1, 3, 1, 3, 1, 3, 0, 1);
		send_box(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, 1, 1);
		wait_drained();
		// filter at reset limit; last word is a dropped box
		write_reg(bpuv_pkg::REG_FILTER_ENABLE, 1);
		send_box(-50, 50, -50, 50, -50, 50, 1, 0);
		send_box(-51, 0, 0, 1, 0, 1, 1, 0);
		send_box(0, 1, 0, 1, 0, 51, 1, 1);
		wait_drained();
		write_reg(bpuv_pkg::REG_FILTER_ENABLE, 0);
		// store overflow with a dropped last box
		for (int b = 0; b < 17; b++)
			send_box(b % 3, b % 3 + 2, 0, 3, -1, b % 2, 1'(b % 2), b == 16);
		wait_drained();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: write_reg(bpuv_pkg::REG_FILTER_LIMIT, $urandom_range(0, 200));
				1: write_reg(bpuv_pkg::REG_FILTER_LIMIT, 0);
				2: write_reg(bpuv_pkg::REG_FILTER_LIMIT, CMAX);
				3: write_reg(bpuv_pkg::REG_FILTER_LIMIT, $urandom_range(20, 90));
				default: write_reg(bpuv_pkg::REG_FILTER_LIMIT, int'(bpuv_pkg::LIMIT_RESET));
			endcase
			write_reg(bpuv_pkg::REG_FILTER_ENABLE, (ph == 0 || ph == 4) ? 0 : 1);
			if (ph == 4)
				calm = 1;
			while (n_items < 25 + 110 * (ph + 1)) begin
				if (ph == 1 && n_items > 25 + 140)
					stall_req = 1;
				random_set();
			end
			box_if.valid = 0;
			wait_drained();
		end

		while (pending != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
		$display("%0d boxes in %0d sets, %0d sets past the store size, filter on and off",
			n_items, n_sets, n_full_sets);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

// ----- files.f -----
rtl/bpuv_pkg.sv
rtl/bpuv_if.sv
rtl/bpuv_ram.sv
rtl/bpuv_queue.sv
rtl/bpuv_front.sv
rtl/bpuv_back.sv
rtl/box_paint_union_volume_core.sv
test/bpuv_volume_checker.sv
test/tb.sv
